### design/logical_immediate_encoder_top_macros.svh
// Assertion macros shared by the logical immediate encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LOGICAL_IMMEDIATE_ENCODER_TOP_MACROS_SVH
`define LOGICAL_IMMEDIATE_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define LIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define LIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LIE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LIE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/lie_pkg.sv
// Types and constants for the logical immediate encoder.
// No dependencies; used by lie_elem, lie_encode and the top level.
package lie_pkg;

  localparam int unsigned ImmW = 64;
  localparam int unsigned EncW = 13;

  // Element size as log2 of its bit count (2 to 64 bits).
  typedef logic [2:0] size_log_t;

  localparam size_log_t SizeLog2  = 3'd1;
  localparam size_log_t SizeLog4  = 3'd2;
  localparam size_log_t SizeLog8  = 3'd3;
  localparam size_log_t SizeLog16 = 3'd4;
  localparam size_log_t SizeLog32 = 3'd5;
  localparam size_log_t SizeLog64 = 3'd6;

  // Element description handed from the analysis stage to the field builder.
  typedef struct packed {
    logic             reject;
    size_log_t        size_log;
    logic [ImmW-1:0]  rise;
    logic [ImmW-1:0]  fall;
  } elem_info_t;

  // Bit position of a one-hot vector; the result is meaningless otherwise.
  function automatic logic [5:0] onehot_index(input logic [ImmW-1:0] oh);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < ImmW; i++) begin
      if (oh[i]) begin
        idx = idx | 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

### design/lie_elem.sv
// Element analysis: repeat size, rejection of all-zero, all-one and over-wide
// values, and the rising/falling edge masks of one element. Depends on lie_pkg.
module lie_elem import lie_pkg::*; (
  input  logic [ImmW-1:0] imm_i,
  input  logic            wide_i,
  output elem_info_t      info_o
);

  logic      eq2, eq4, eq8, eq16, eq32;
  size_log_t inner_log;
  size_log_t size_log;
  logic [ImmW-1:0] emask;
  logic [ImmW-1:0] elem;
  logic [ImmW-1:0] prev;
  logic            top_bit;
  logic            reject;

  always_comb begin
    eq2  = (imm_i[1:0]  == imm_i[3:2]);
    eq4  = (imm_i[3:0]  == imm_i[7:4]);
    eq8  = (imm_i[7:0]  == imm_i[15:8]);
    eq16 = (imm_i[15:0] == imm_i[31:16]);
    eq32 = (imm_i[31:0] == imm_i[63:32]);

    // Halving stops at the first size whose halves differ.
    if (!eq16) begin
      inner_log = SizeLog32;
    end else if (!eq8) begin
      inner_log = SizeLog16;
    end else if (!eq4) begin
      inner_log = SizeLog8;
    end else if (!eq2) begin
      inner_log = SizeLog4;
    end else begin
      inner_log = SizeLog2;
    end

    if (wide_i && !eq32) begin
      size_log = SizeLog64;
    end else begin
      size_log = inner_log;
    end

    case (size_log)
      SizeLog2: begin
        emask   = 64'h0000_0000_0000_0003;
        top_bit = imm_i[1];
      end
      SizeLog4: begin
        emask   = 64'h0000_0000_0000_000F;
        top_bit = imm_i[3];
      end
      SizeLog8: begin
        emask   = 64'h0000_0000_0000_00FF;
        top_bit = imm_i[7];
      end
      SizeLog16: begin
        emask   = 64'h0000_0000_0000_FFFF;
        top_bit = imm_i[15];
      end
      SizeLog32: begin
        emask   = 64'h0000_0000_FFFF_FFFF;
        top_bit = imm_i[31];
      end
      default: begin
        emask   = '1;
        top_bit = imm_i[63];
      end
    endcase

    elem = imm_i & emask;
    // Each bit compared with its lower neighbor, wrapping inside the element.
    prev = {elem[ImmW-2:0], top_bit};

    if (wide_i) begin
      reject = (imm_i == '0) || (imm_i == '1);
    end else begin
      reject = (imm_i == '0) || (imm_i[63:32] != '0) || (imm_i[31:0] == '1);
    end

    info_o.reject   = reject;
    info_o.size_log = size_log;
    info_o.rise     = elem & ~prev & emask;
    info_o.fall     = ~elem & prev & emask;
  end

endmodule

### design/lie_encode.sv
// Field builder: checks for a single rotated run and forms N:immr:imms.
// Depends on lie_pkg.
module lie_encode import lie_pkg::*; (
  input  elem_info_t      info_i,
  output logic            ok_o,
  output logic [EncW-1:0] enc_o
);

  logic [5:0] smask;
  logic [5:0] rot;
  logic [5:0] fall_idx;
  logic [5:0] ones;
  logic [5:0] immr;
  logic [5:0] imms;
  logic [6:0] pre;
  logic       n_bit;
  logic       single_run;

  always_comb begin
    smask    = 6'((7'd1 << info_i.size_log) - 7'd1);
    // Exactly one rising edge means the element is one rotated run of ones.
    single_run = (info_i.rise != '0) &&
                 ((info_i.rise & (info_i.rise - 64'd1)) == '0);
    rot      = onehot_index(info_i.rise);
    fall_idx = onehot_index(info_i.fall);
    ones     = (fall_idx - rot) & smask;
    immr     = (6'd0 - rot) & smask;
    pre      = ~({smask, 1'b0} | 7'd1);
    imms     = pre[5:0] | ((ones - 6'd1) & smask);
    n_bit    = ~pre[6];

    ok_o = !info_i.reject && single_run;
    if (ok_o) begin
      enc_o = {n_bit, immr, imms};
    end else begin
      enc_o = '0;
    end
  end

endmodule

### design/logical_immediate_encoder_top.sv
// Logical immediate encoder: AArch64 bitmask immediate to N:immr:imms.
// Depends on lie_pkg, lie_elem, lie_encode and the assertion macro header.
//
// One item per clock cycle is accepted while the output side is ready, and one
// result item leaves per item: the immediate is captured in an input register,
// analyzed and encoded in one combinational pass, and the result is held in an
// output register. A stalled result does not block an empty input register, so
// one further item is taken while it waits.
// Rejected values leave with ok low and an all-zero encoding.
`include "logical_immediate_encoder_top_macros.svh"

module logical_immediate_encoder_top import lie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] immediate
  input  logic [0:0]  s_axis_tuser,   // [0] wide_mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [12:0] encoding, [15:13] zero
  output logic [0:0]  m_axis_tuser    // [0] ok
);

  logic            st_valid_q;
  logic [ImmW-1:0] st_imm_q;
  logic            st_wide_q;
  logic            out_valid_q;
  logic            res_ok_q;
  logic [EncW-1:0] res_enc_q;

  logic            out_ready;
  logic            st_ready;
  elem_info_t      info;
  logic            res_ok_d;
  logic [EncW-1:0] res_enc_d;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign st_ready      = !st_valid_q || out_ready;
  assign s_axis_tready = st_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_ready) begin
        st_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= st_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready && s_axis_tvalid) begin
      st_imm_q  <= s_axis_tdata;
      st_wide_q <= s_axis_tuser[0];
    end
    if (out_ready && st_valid_q) begin
      res_ok_q  <= res_ok_d;
      res_enc_q <= res_enc_d;
    end
  end

  lie_elem u_elem (
    .imm_i  (st_imm_q),
    .wide_i (st_wide_q),
    .info_o (info)
  );

  lie_encode u_encode (
    .info_i (info),
    .ok_o   (res_ok_d),
    .enc_o  (res_enc_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_enc_q};
  assign m_axis_tuser  = res_ok_q;

  // A held item moves to the output register whenever that register frees up.
  `LIE_ASSERT_NEXT(a_item_advances, clk_i, rst_ni, st_valid_q && out_ready, out_valid_q)
  // An item waiting behind a stalled result is never dropped.
  `LIE_ASSERT_NEXT(a_item_kept, clk_i, rst_ni, st_valid_q && !out_ready, st_valid_q)
  // A rejected value always carries an all-zero encoding.
  `LIE_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, out_valid_q && !res_ok_q, res_enc_q == '0)
  // The N bit is only set for a full 64-bit element, which needs 64-bit mode.
  `LIE_ASSERT_IMP(a_n_needs_wide, clk_i, rst_ni, st_valid_q && res_ok_d && res_enc_d[12],
                  st_wide_q)

endmodule
